### rtl/fpct_pkg.sv
// Shared types and constants for the frustum plane cull test block.
// No dependencies; used by the top, the multiply-accumulate unit and the checker.
package fpct_pkg;

  localparam int S_TDATA_W = 320;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 8;

  localparam int COEFF_W  = 32;
  localparam int CENTER_W = 32;
  localparam int EXTENT_W = 31;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 67;
  localparam int TERM_W   = 3;

  localparam logic [S_TUSER_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [S_TUSER_W-1:0] OP_POINT  = 3'd1;
  localparam logic [S_TUSER_W-1:0] OP_SPHERE = 3'd2;
  localparam logic [S_TUSER_W-1:0] OP_CUBE   = 3'd3;
  localparam logic [S_TUSER_W-1:0] OP_BOX    = 3'd4;

  localparam logic [TERM_W-1:0] TERM_AX   = 3'd0;
  localparam logic [TERM_W-1:0] TERM_BY   = 3'd1;
  localparam logic [TERM_W-1:0] TERM_CZ   = 3'd2;
  localparam logic [TERM_W-1:0] TERM_AEX  = 3'd3;
  localparam logic [TERM_W-1:0] TERM_BEY  = 3'd4;
  localparam logic [TERM_W-1:0] TERM_CEZ  = 3'd5;

  typedef struct packed {
    logic signed [COEFF_W-1:0] a;
    logic signed [COEFF_W-1:0] b;
    logic signed [COEFF_W-1:0] c;
    logic signed [COEFF_W-1:0] d;
  } plane_t;

  typedef struct packed {
    logic init;
    logic issue;
  } mac_ctrl_t;

endpackage

### rtl/frustum_plane_cull_test_top.sv
// Frustum plane cull test: a plane register file, a shared multiply-accumulate
// unit and the sequencer that runs it. Depends on fpct_pkg, fpct_planes, fpct_mac.
//
// A load transfer writes one clip plane and gives no result. A test transfer
// runs the planes one after another through one 33x33 multiplier that yields
// a single product per cycle, ending early at the first plane that culls the
// shape; the input is held off until the test ends. The result sits in an
// output register, so a new item can be accepted while it waits; a later
// test that finishes before that result is taken holds in its last step
// until the output is free.
module frustum_plane_cull_test_top #(
  parameter int PLANE_COUNT   = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // plane_index, plane_a, plane_b, plane_c, plane_d, center_x, center_y,
  // center_z, extent_x, extent_y, extent_z
  input  logic [fpct_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  logic [fpct_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // inside_res, then zero fill
  output logic [fpct_pkg::M_TDATA_W-1:0]   m_tdata
);
  import fpct_pkg::*;

  localparam int PIDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_INIT, S_RUN, S_DRAIN, S_CHECK
  } state_t;

  state_t state;

  logic [2:0]                  plane_index;
  plane_t                      load_plane;
  logic signed [CENTER_W-1:0]  center_x, center_y, center_z;
  logic [EXTENT_W-1:0]         extent_x, extent_y, extent_z;

  logic [S_TUSER_W-1:0]        op_q;
  logic signed [CENTER_W-1:0]  cx_q, cy_q, cz_q;
  logic [EXTENT_W-1:0]         ex_q, ey_q, ez_q;
  logic [PIDX_W-1:0]           pcnt;
  logic [TERM_W-1:0]           term;
  logic                        inside_res;

  plane_t                      cur_plane;
  mac_ctrl_t                   mac_ctrl;
  logic signed [ACC_W-1:0]     init_val;
  logic signed [MUL_W-1:0]     op_a, op_b;
  logic                        acc_neg;
  logic [TERM_W-1:0]           term_sel;
  logic [TERM_W-1:0]           last_term;
  logic                        load_we;
  logic                        last_plane;
  logic                        res_fire;

  assign plane_index  = s_tdata[2:0];
  assign load_plane.a = s_tdata[34:3];
  assign load_plane.b = s_tdata[66:35];
  assign load_plane.c = s_tdata[98:67];
  assign load_plane.d = s_tdata[130:99];
  assign center_x     = s_tdata[162:131];
  assign center_y     = s_tdata[194:163];
  assign center_z     = s_tdata[226:195];
  assign extent_x     = s_tdata[257:227];
  assign extent_y     = s_tdata[288:258];
  assign extent_z     = s_tdata[319:289];

  assign s_tready = (state == S_IDLE);
  assign load_we  = s_tvalid && s_tready && (s_tuser == OP_LOAD) &&
                    ({1'b0, plane_index} < 4'(PLANE_COUNT));

  fpct_planes #(
    .WIDTH  ($bits(plane_t)),
    .DEPTH  (PLANE_COUNT),
    .ADDR_W (PIDX_W)
  ) u_planes (
    .clk   (clk),
    .we    (load_we),
    .waddr (plane_index[PIDX_W-1:0]),
    .wdata (load_plane),
    .raddr (pcnt),
    .rdata (cur_plane)
  );

  function automatic logic signed [MUL_W-1:0] abs_coeff(logic signed [COEFF_W-1:0] v);
    logic signed [MUL_W-1:0] w;
    w = MUL_W'(v);
    return w[MUL_W-1] ? -w : w;
  endfunction

  assign last_term  = ((op_q == OP_CUBE) || (op_q == OP_BOX)) ? TERM_CEZ : TERM_CZ;
  assign last_plane = (pcnt == PIDX_W'(PLANE_COUNT - 1));
  assign term_sel   = (state == S_INIT) ? TERM_AX : term;
  assign res_fire   = (state == S_CHECK) && (acc_neg || last_plane) &&
                      (!m_tvalid || m_tready);

  always_comb begin
    mac_ctrl.init  = (state == S_INIT);
    mac_ctrl.issue = (state == S_INIT) || (state == S_RUN);
    init_val = ACC_W'(cur_plane.d) <<< FRACTION_BITS;
    if (op_q == OP_SPHERE) begin
      init_val = init_val + (ACC_W'(ex_q) <<< FRACTION_BITS);
    end
    case (term_sel)
      TERM_AX: begin
        op_a = MUL_W'(cur_plane.a);
        op_b = MUL_W'(cx_q);
      end
      TERM_BY: begin
        op_a = MUL_W'(cur_plane.b);
        op_b = MUL_W'(cy_q);
      end
      TERM_CZ: begin
        op_a = MUL_W'(cur_plane.c);
        op_b = MUL_W'(cz_q);
      end
      TERM_AEX: begin
        op_a = abs_coeff(cur_plane.a);
        op_b = $signed({2'b00, ex_q});
      end
      TERM_BEY: begin
        op_a = abs_coeff(cur_plane.b);
        op_b = $signed({2'b00, ey_q});
      end
      TERM_CEZ: begin
        op_a = abs_coeff(cur_plane.c);
        op_b = $signed({2'b00, ez_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  fpct_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .init_val (init_val),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc_neg  (acc_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      pcnt     <= '0;
      term     <= TERM_AX;
    end else begin
      if (res_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          pcnt <= '0;
          if (s_tvalid) begin
            op_q <= s_tuser;
            cx_q <= center_x;
            cy_q <= center_y;
            cz_q <= center_z;
            ex_q <= extent_x;
            ey_q <= (s_tuser == OP_CUBE) ? extent_x : extent_y;
            ez_q <= (s_tuser == OP_CUBE) ? extent_x : extent_z;
            if (s_tuser inside {[OP_POINT:OP_BOX]}) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_INIT;
        end
        S_INIT: begin
          term  <= TERM_BY;
          state <= S_RUN;
        end
        S_RUN: begin
          if (term == last_term) begin
            state <= S_DRAIN;
          end else begin
            term <= term + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (res_fire) begin
            inside_res <= !acc_neg;
            state      <= S_IDLE;
          end else if (!acc_neg && !last_plane) begin
            pcnt  <= pcnt + 1'b1;
            state <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, inside_res};

endmodule

### rtl/fpct_planes.sv
// Generic RAM with one write port and one registered read port.
// No dependencies; the instance sets the word width, the depth and the address width.
module fpct_planes #(
  parameter int WIDTH  = 128,
  parameter int DEPTH  = 6,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fpct_mac.sv
// Shared multiply-accumulate unit: one 33x33 signed product per cycle,
// registered, then added into a wide exact accumulator. Depends on fpct_pkg.
module fpct_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  fpct_pkg::mac_ctrl_t               ctrl,
  input  logic signed [fpct_pkg::ACC_W-1:0] init_val,
  input  logic signed [fpct_pkg::MUL_W-1:0] op_a,
  input  logic signed [fpct_pkg::MUL_W-1:0] op_b,
  output logic                              acc_neg
);
  import fpct_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
    prod <= op_a * op_b;
    if (ctrl.init) begin
      acc <= init_val;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign acc_neg = acc[ACC_W-1];

endmodule

### rtl/fpct_checker.sv
// Port-level checker for the frustum plane cull test block, bound to the top.
// Depends on fpct_pkg for operation codes and port widths.
module fpct_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [fpct_pkg::S_TUSER_W-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fpct_pkg::M_TDATA_W-1:0] m_tdata
);
  import fpct_pkg::*;

  // A result that is offered but not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transfer changed while stalled");

  // A test transfer keeps the block busy for at least the next cycle.
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_POINT || s_tuser == OP_SPHERE ||
    s_tuser == OP_CUBE || s_tuser == OP_BOX) |=> !s_tready)
    else $error("block ready right after a test transfer");

  // A load leaves the block ready in the next cycle and never brings up a result.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_LOAD) |=> s_tready && !$rose(m_tvalid))
    else $error("load transfer stalled the block or made a result");

  // Only the inside flag carries information in the output word.
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
    else $error("output fill bits not zero");

endmodule

bind frustum_plane_cull_test_top fpct_checker u_checker (.*);
